### rtl/core/sgpa_pkg.sv
// shared constants and types for the streaming graph partition assign unit
package sgpa_pkg;

   localparam int unsigned NUM_PARTITIONS = 8;
   localparam int unsigned MAX_VERTICES   = 65536;

   localparam int unsigned PIDX_W  = $clog2(NUM_PARTITIONS);
   localparam int unsigned SEED_W  = $clog2(NUM_PARTITIONS + 1);
   localparam int unsigned ADDR_W  = $clog2(MAX_VERTICES);
   localparam int unsigned OWNER_W = 4;
   localparam int unsigned ENTRY_W = OWNER_W + 1;

   localparam int unsigned ID_W    = 16;
   localparam int unsigned CNT_W   = 16;
   localparam int unsigned SIZE_W  = 17;
   localparam int unsigned EDGE_W  = 32;
   localparam int unsigned PART_W  = 3;
   localparam int unsigned ALPHA_W = 24;
   localparam int unsigned CAND_W  = 4;

   // square root of (size << 16), size up to 2^17
   localparam int unsigned ROOT_W  = 17;
   localparam int unsigned RAD_W   = 2 * ROOT_W;

   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAND  = 1'd1;

   localparam logic CMD_NEIGHBOR = 1'b0;
   localparam logic CMD_PLACE    = 1'b1;

endpackage

### rtl/core/streaming_graph_partition_assign_unit.sv
// top level: streaming graph partition assignment with a shared sqrt and multiplier
//
// usage
// - request channel: start, busy, req_cmd, req_vertex_id, req_neighbor_id. a request
//   is taken at a clock edge with start high and busy low
// - a neighbor request (req_cmd low) looks up the neighbor's owner in the owner ram
//   and bumps that partition's counter; it gives no result
// - a place request (req_cmd high) gives exactly one result, shown for one cycle
//   with rsp_valid high, in the first cycle the block is idle again
// - the first partitions-many placements seed partitions in turn
// - later placements walk all partitions in index order; each of the
//   candidate_count smallest ones is scored with two passes through the sqrt
//   unit (17 steps each) and three multiplies on the one shared multiplier;
//   the other partitions are only ranked and passed over
// - the receiver cannot stall; the result is there for one cycle only
// - reset starts a clearing pass over all 65536 owner ram entries, one entry a
//   cycle, with busy high; csr writes are taken at any time
// - csr: csr_write, csr_index, csr_wdata; index 0 alpha_q16, index 1 candidate_count
module streaming_graph_partition_assign_unit
   import sgpa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_cmd,
   input  logic [ID_W-1:0]      req_vertex_id,
   input  logic [ID_W-1:0]      req_neighbor_id,
   output logic                 rsp_valid,
   output logic [PART_W-1:0]    rsp_partition,
   output logic [CNT_W-1:0]     rsp_edges_added,
   output logic [SIZE_W-1:0]    rsp_partition_size,
   output logic [EDGE_W-1:0]    rsp_partition_edges,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ALPHA_W-1:0]   csr_wdata
);

   localparam int unsigned X_W   = SIZE_W + 1;
   localparam int unsigned MUL_W = 2 * ALPHA_W;
   localparam int unsigned P_W   = X_W + ROOT_W;
   localparam int unsigned SC_W  = EDGE_W + 2;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_NB_UPD, ST_RANK, ST_SQ0, ST_M0, ST_M0W,
      ST_SQ1, ST_M1, ST_M1W, ST_MA, ST_MAW, ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        clr_addr_ff, clr_addr_in;
   logic [ALPHA_W-1:0]       alpha_ff, alpha_in;
   logic [CAND_W-1:0]        cand_ff, cand_in;
   logic [SEED_W-1:0]        seeded_ff, seeded_in;
   logic [CNT_W-1:0]         cnt_ff [NUM_PARTITIONS];
   logic [CNT_W-1:0]         cnt_in [NUM_PARTITIONS];
   logic [SIZE_W-1:0]        size_ff [NUM_PARTITIONS];
   logic [SIZE_W-1:0]        size_in [NUM_PARTITIONS];
   logic [EDGE_W-1:0]        edge_ff [NUM_PARTITIONS];
   logic [EDGE_W-1:0]        edge_in [NUM_PARTITIONS];
   logic [ID_W-1:0]          vid_ff, vid_in;
   logic                     nb_ok_ff, nb_ok_in;
   logic                     seed_ff, seed_in;
   logic [PIDX_W-1:0]        cur_p_ff, cur_p_in;
   logic [X_W-1:0]           x_ff, x_in;
   logic [P_W-1:0]           p0_ff, p0_in;
   logic [ALPHA_W-1:0]       dp_ff, dp_in;
   logic [MUL_W-1:0]         mul_ff, mul_in;
   logic signed [SC_W-1:0]   best_sc_ff, best_sc_in;
   logic [PIDX_W-1:0]        best_rank_ff, best_rank_in;
   logic [PIDX_W-1:0]        best_p_ff, best_p_in;
   logic                     have_ff, have_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PART_W-1:0]        rsp_part_ff, rsp_part_in;
   logic [CNT_W-1:0]         rsp_added_ff, rsp_added_in;
   logic [SIZE_W-1:0]        rsp_size_ff, rsp_size_in;
   logic [EDGE_W-1:0]        rsp_edges_ff, rsp_edges_in;

   // owner ram ports
   logic                     ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [ENTRY_W-1:0]       ram_wr_data, ram_rd_data;

   // sqrt unit
   logic                     sq_start, sq_done;
   logic [RAD_W-1:0]         sq_radicand;
   logic [ROOT_W-1:0]        sq_root;

   // shared multiplier operands
   logic [ALPHA_W-1:0]       mul_a, mul_b;

   logic                     accept;
   logic [PIDX_W-1:0]        sel_p;
   logic [OWNER_W-1:0]       nb_owner;
   logic [CNT_W-1:0]         cnt_sel;
   logic [SIZE_W-1:0]        size_sel;
   logic [EDGE_W-1:0]        edge_sel;
   logic [PIDX_W-1:0]        rank;
   logic [SEED_W-1:0]        n_eff;
   logic [CNT_W-1:0]         added;
   logic [EDGE_W:0]          edge_sum;
   logic [EDGE_W-1:0]        pen;
   logic signed [SC_W-1:0]   score;
   logic                     better;

   assign accept   = start && (state_ff == ST_IDLE);
   assign nb_owner = ram_rd_data[OWNER_W-1:0];

   // one read index for the per-partition arrays
   always_comb begin
      case (state_ff)
         ST_NB_UPD: sel_p = PIDX_W'(nb_owner);
         ST_FINISH: sel_p = best_p_ff;
         default:   sel_p = cur_p_ff;
      endcase
   end

   assign cnt_sel  = cnt_ff[sel_p];
   assign size_sel = size_ff[sel_p];
   assign edge_sel = edge_ff[sel_p];

   // rank of the current partition in (size, index) order
   always_comb begin
      rank = '0;
      for (int q = 0; q < NUM_PARTITIONS; q++) begin
         if ((size_ff[q] < size_ff[cur_p_ff]) ||
             ((size_ff[q] == size_ff[cur_p_ff]) && (PIDX_W'(q) < cur_p_ff))) begin
            rank = rank + 1'b1;
         end
      end
   end

   // candidate count, zero acts as one and the top is clipped
   always_comb begin
      if (cand_ff == '0) begin
         n_eff = SEED_W'(1);
      end else if (32'(cand_ff) > NUM_PARTITIONS) begin
         n_eff = SEED_W'(NUM_PARTITIONS);
      end else begin
         n_eff = SEED_W'(cand_ff);
      end
   end

   // score = edges * 256 - (alpha * (P(s+1) - P(s))) >> 16
   assign pen   = mul_ff[MUL_W-1:16];
   assign score = $signed({2'b00, 8'(0), cnt_sel, 8'b0}) - $signed({2'b00, pen});
   assign better = !have_ff || (score > best_sc_ff) ||
                   ((score == best_sc_ff) && (rank < best_rank_ff));

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_MA: begin
            mul_a = alpha_ff;
            mul_b = dp_ff;
         end
         default: begin
            mul_a = ALPHA_W'(x_ff);
            mul_b = ALPHA_W'(sq_root);
         end
      endcase
   end

   assign added    = seed_ff ? '0 : cnt_sel;
   assign edge_sum = {1'b0, edge_sel} + (EDGE_W + 1)'(added);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      alpha_in     = alpha_ff;
      cand_in      = cand_ff;
      seeded_in    = seeded_ff;
      cnt_in       = cnt_ff;
      size_in      = size_ff;
      edge_in      = edge_ff;
      vid_in       = vid_ff;
      nb_ok_in     = nb_ok_ff;
      seed_in      = seed_ff;
      cur_p_in     = cur_p_ff;
      x_in         = x_ff;
      p0_in        = p0_ff;
      dp_in        = dp_ff;
      mul_in       = mul_a * mul_b;
      best_sc_in   = best_sc_ff;
      best_rank_in = best_rank_ff;
      best_p_in    = best_p_ff;
      have_in      = have_ff;
      rsp_valid_in = 1'b0;
      rsp_part_in  = rsp_part_ff;
      rsp_added_in = rsp_added_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_edges_in = rsp_edges_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = clr_addr_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      sq_start     = 1'b0;
      sq_radicand  = {x_ff, 16'b0};

      if (csr_write) begin
         case (csr_index)
            REG_ALPHA: alpha_in = csr_wdata;
            REG_CAND:  cand_in  = csr_wdata[CAND_W-1:0];
            default:   ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            // owner ram clearing pass after reset
            ram_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(MAX_VERTICES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_NEIGHBOR) begin
                  ram_rd_en = 1'b1;
                  nb_ok_in  = 32'(req_neighbor_id) < MAX_VERTICES;
                  state_in  = ST_NB_UPD;
               end else begin
                  vid_in = req_vertex_id;
                  if (32'(seeded_ff) < NUM_PARTITIONS) begin
                     best_p_in = PIDX_W'(seeded_ff);
                     seeded_in = seeded_ff + 1'b1;
                     seed_in   = 1'b1;
                     state_in  = ST_FINISH;
                  end else begin
                     seed_in  = 1'b0;
                     cur_p_in = '0;
                     have_in  = 1'b0;
                     state_in = ST_RANK;
                  end
               end
            end
         end
         ST_NB_UPD: begin
            if (nb_ok_ff && ram_rd_data[OWNER_W] &&
                (32'(nb_owner) < NUM_PARTITIONS) && (cnt_sel != '1)) begin
               cnt_in[sel_p] = cnt_sel + 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_RANK: begin
            if (SEED_W'(rank) < n_eff) begin
               x_in        = X_W'(size_sel);
               sq_start    = 1'b1;
               sq_radicand = {1'b0, size_sel, 16'b0};
               state_in    = ST_SQ0;
            end else if (cur_p_ff == PIDX_W'(NUM_PARTITIONS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cur_p_in = cur_p_ff + 1'b1;
            end
         end
         ST_SQ0: begin
            if (sq_done) begin
               state_in = ST_M0;
            end
         end
         ST_M0: begin
            state_in = ST_M0W;
         end
         ST_M0W: begin
            // P(s) captured, start sqrt of (s+1) << 16
            p0_in       = mul_ff[P_W-1:0];
            x_in        = x_ff + 1'b1;
            sq_start    = 1'b1;
            sq_radicand = {X_W'(x_ff + 1'b1), 16'b0};
            state_in    = ST_SQ1;
         end
         ST_SQ1: begin
            if (sq_done) begin
               state_in = ST_M1;
            end
         end
         ST_M1: begin
            state_in = ST_M1W;
         end
         ST_M1W: begin
            // the step P(s+1) - P(s) stays below 2^19
            dp_in    = ALPHA_W'(mul_ff[P_W-1:0] - p0_ff);
            state_in = ST_MA;
         end
         ST_MA: begin
            state_in = ST_MAW;
         end
         ST_MAW: begin
            if (better) begin
               best_sc_in   = score;
               best_rank_in = rank;
               best_p_in    = cur_p_ff;
               have_in      = 1'b1;
            end
            if (cur_p_ff == PIDX_W'(NUM_PARTITIONS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cur_p_in = cur_p_ff + 1'b1;
               state_in = ST_RANK;
            end
         end
         ST_FINISH: begin
            if (32'(vid_ff) < MAX_VERTICES) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = ADDR_W'(vid_ff);
               ram_wr_data = {1'b1, OWNER_W'(best_p_ff)};
            end
            if (size_sel != '1) begin
               size_in[sel_p] = size_sel + 1'b1;
            end
            edge_in[sel_p] = edge_sum[EDGE_W] ? '1 : edge_sum[EDGE_W-1:0];
            rsp_valid_in = 1'b1;
            rsp_part_in  = PART_W'(best_p_ff);
            rsp_added_in = added;
            rsp_size_in  = (size_sel != '1) ? size_sel + 1'b1 : size_sel;
            rsp_edges_in = edge_sum[EDGE_W] ? '1 : edge_sum[EDGE_W-1:0];
            for (int p = 0; p < NUM_PARTITIONS; p++) begin
               cnt_in[p] = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         alpha_ff     <= ALPHA_W'(32768);
         cand_ff      <= CAND_W'(4);
         seeded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < NUM_PARTITIONS; p++) begin
            cnt_ff[p]  <= '0;
            size_ff[p] <= '0;
            edge_ff[p] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         alpha_ff     <= alpha_in;
         cand_ff      <= cand_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         size_ff      <= size_in;
         edge_ff      <= edge_in;
      end
      vid_ff       <= vid_in;
      nb_ok_ff     <= nb_ok_in;
      seed_ff      <= seed_in;
      cur_p_ff     <= cur_p_in;
      x_ff         <= x_in;
      p0_ff        <= p0_in;
      dp_ff        <= dp_in;
      mul_ff       <= mul_in;
      best_sc_ff   <= best_sc_in;
      best_rank_ff <= best_rank_in;
      best_p_ff    <= best_p_in;
      have_ff      <= have_in;
      rsp_part_ff  <= rsp_part_in;
      rsp_added_ff <= rsp_added_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_edges_ff <= rsp_edges_in;
   end

   sgpa_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_VERTICES)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ADDR_W'(req_neighbor_id)),
      .rd_data (ram_rd_data)
   );

   sgpa_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_radicand),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_partition       = rsp_part_ff;
   assign rsp_edges_added     = rsp_added_ff;
   assign rsp_partition_size  = rsp_size_ff;
   assign rsp_partition_edges = rsp_edges_ff;

endmodule

### rtl/core/sgpa_ram.sv
// generic single write, single read ram with registered read data
module sgpa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/sgpa_isqrt.sv
// iterative floor square root, one result bit per cycle
module sgpa_isqrt
   import sgpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int unsigned REM_W  = ROOT_W + 2;
   localparam int unsigned STEP_W = $clog2(ROOT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (step_ff == STEP_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### rtl/core/sgpa_checker.sv
// port level checks for the streaming graph partition assign unit
module sgpa_port_checks
   import sgpa_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [CNT_W-1:0]     rsp_edges_added,
   input logic [SIZE_W-1:0]    rsp_partition_size,
   input logic [EDGE_W-1:0]    rsp_partition_edges
);

   // reset starts the owner clearing pass
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken without going busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results back to back");

   a_rsp_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_partition_size != '0))
      else $error("empty partition reported");

   a_rsp_edges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_edges_added) <= rsp_partition_edges))
      else $error("edge total below edges added");

endmodule

bind streaming_graph_partition_assign_unit sgpa_port_checks u_sgpa_port_checks (.*);

### tb/sv/sgpa_checker.sv
// checker for the partition assign unit: predicts each placement and compares results
`timescale 1ns / 1ps
module sgpa_checker
   import sgpa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic                 req_cmd,
   input  logic [ID_W-1:0]      req_vertex_id,
   input  logic [ID_W-1:0]      req_neighbor_id,
   input  logic                 rsp_valid,
   input  logic [PART_W-1:0]    rsp_partition,
   input  logic [CNT_W-1:0]     rsp_edges_added,
   input  logic [SIZE_W-1:0]    rsp_partition_size,
   input  logic [EDGE_W-1:0]    rsp_partition_edges,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ALPHA_W-1:0]   csr_wdata,
   output int unsigned          fail_count,
   output int unsigned          pending
);

   typedef struct packed {
      logic [PART_W-1:0] part;
      logic [CNT_W-1:0]  added;
      logic [SIZE_W-1:0] size;
      logic [EDGE_W-1:0] edges;
   } placement_type;

   placement_type placements_due[$];

   bit                 owned [MAX_VERTICES];
   logic [OWNER_W-1:0] owner_of [MAX_VERTICES];
   logic [CNT_W-1:0]   nbr_hits [NUM_PARTITIONS];
   logic [SIZE_W-1:0]  part_size [NUM_PARTITIONS];
   logic [EDGE_W-1:0]  part_edges [NUM_PARTITIONS];
   int unsigned        seeds_done;
   logic [ALPHA_W-1:0] alpha;
   logic [CAND_W-1:0]  cand;
   int unsigned        mismatches;

   assign pending    = placements_due.size();
   assign fail_count = mismatches;

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // x^1.5 scaled by 256
   function automatic longint unsigned growth(longint unsigned x);
      return x * root_floor(x << 16);
   endfunction

   function automatic longint fennel_score(int unsigned p);
      longint unsigned s, dp, pen;
      s   = part_size[p];
      dp  = growth(s + 1) - growth(s);
      pen = (longint'(alpha) * dp) >> 16;
      return longint'(nbr_hits[p]) * 256 - longint'(pen);
   endfunction

   function automatic placement_type place_vertex(logic [ID_W-1:0] vid);
      int unsigned order [NUM_PARTITIONS];
      int unsigned n, chosen, t, j;
      logic [CNT_W-1:0] added;
      longint best, sc;
      longint unsigned e;
      placement_type r;
      if (seeds_done < NUM_PARTITIONS) begin
         chosen = seeds_done;
         seeds_done++;
         added = '0;
      end else begin
         n = cand;
         if (n < 1) n = 1;
         if (n > NUM_PARTITIONS) n = NUM_PARTITIONS;
         for (int i = 0; i < NUM_PARTITIONS; i++) order[i] = i;
         // insertion sort by (size, index)
         for (int i = 1; i < NUM_PARTITIONS; i++) begin
            t = order[i];
            j = i;
            while (j > 0 && (part_size[order[j-1]] > part_size[t] ||
                   (part_size[order[j-1]] == part_size[t] && order[j-1] > t))) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = t;
         end
         chosen = order[0];
         best = fennel_score(order[0]);
         for (int i = 1; i < n; i++) begin
            sc = fennel_score(order[i]);
            if (sc > best) begin
               best = sc;
               chosen = order[i];
            end
         end
         added = nbr_hits[chosen];
      end
      owned[vid]    = 1'b1;
      owner_of[vid] = OWNER_W'(chosen);
      if (part_size[chosen] != '1) part_size[chosen]++;
      e = longint'(part_edges[chosen]) + added;
      part_edges[chosen] = (e > 64'hFFFF_FFFF) ? '1 : e[EDGE_W-1:0];
      for (int i = 0; i < NUM_PARTITIONS; i++) nbr_hits[i] = '0;
      r.part  = chosen[PART_W-1:0];
      r.added = added;
      r.size  = part_size[chosen];
      r.edges = part_edges[chosen];
      return r;
   endfunction

   always @(posedge clock) begin
      placement_type exp_r;
      if (reset) begin
         for (int i = 0; i < MAX_VERTICES; i++) owned[i] = 1'b0;
         for (int i = 0; i < NUM_PARTITIONS; i++) begin
            nbr_hits[i]   = '0;
            part_size[i]  = '0;
            part_edges[i] = '0;
         end
         seeds_done = 0;
         alpha = 24'd32768;
         cand  = 4'd4;
         mismatches = 0;
         placements_due.delete();
      end else begin
         if (rsp_valid) begin
            if (placements_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result, partition %0d", rsp_partition);
            end else begin
               exp_r = placements_due.pop_front();
               if (exp_r.part !== rsp_partition || exp_r.added !== rsp_edges_added ||
                   exp_r.size !== rsp_partition_size || exp_r.edges !== rsp_partition_edges) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp part %0d added %0d size %0d edges %0d, got %0d %0d %0d %0d",
                              exp_r.part, exp_r.added, exp_r.size, exp_r.edges, rsp_partition,
                              rsp_edges_added, rsp_partition_size, rsp_partition_edges);
               end
            end
         end
         if (csr_write) begin
            if (csr_index == REG_ALPHA) alpha = csr_wdata;
            else if (csr_index == REG_CAND) cand = csr_wdata[CAND_W-1:0];
         end
         if (start && !busy) begin
            if (req_cmd == CMD_PLACE) begin
               placements_due.push_back(place_vertex(req_vertex_id));
            end else if (owned[req_neighbor_id]) begin
               if (nbr_hits[owner_of[req_neighbor_id]] != '1)
                  nbr_hits[owner_of[req_neighbor_id]]++;
            end
         end
      end
   end

endmodule

### tb/sv/tb_streaming_graph_partition_assign_unit.sv
// top of the partition assign unit testbench: stimulus, config phases and verdict
`timescale 1ns / 1ps
module tb_streaming_graph_partition_assign_unit;
   import sgpa_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_cmd = CMD_NEIGHBOR;
   logic [ID_W-1:0]      req_vertex_id = '0;
   logic [ID_W-1:0]      req_neighbor_id = '0;
   logic                 rsp_valid;
   logic [PART_W-1:0]    rsp_partition;
   logic [CNT_W-1:0]     rsp_edges_added;
   logic [SIZE_W-1:0]    rsp_partition_size;
   logic [EDGE_W-1:0]    rsp_partition_edges;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_ALPHA;
   logic [ALPHA_W-1:0]   csr_wdata = '0;
   int unsigned          fail_count, pending;

   // vertices placed so far, source of well-formed neighbor ids
   logic [ID_W-1:0] placed_ids[$];
   bit              no_gaps;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   streaming_graph_partition_assign_unit dut (.*);

   sgpa_checker chk (.*);

   // all drives happen at the falling edge; a request holds until the block takes it
   task automatic issue(logic cmd, logic [ID_W-1:0] vid, logic [ID_W-1:0] nid);
      start = 1'b1;
      req_cmd = cmd;
      req_vertex_id = vid;
      req_neighbor_id = nid;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (cmd == CMD_PLACE) placed_ids.push_back(vid);
      // random idle gap between requests
      if (!no_gaps && $urandom_range(99) < 22) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   // wait for every result, then let any trailing neighbor request finish
   task automatic drain();
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic set_reg(logic [CSR_IDX_W-1:0] idx, logic [ALPHA_W-1:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   function automatic logic [ID_W-1:0] known_id();
      if (placed_ids.size() == 0) return ID_W'($urandom);
      return placed_ids[$urandom_range(placed_ids.size() - 1)];
   endfunction

   // one vertex: a few neighbors, mostly already placed, then the place request
   task automatic vertex_burst(ref int unsigned sent);
      logic [ID_W-1:0] nid, vid;
      int unsigned k;
      k = $urandom_range(0, 6);
      for (int i = 0; i < k; i++) begin
         if ($urandom_range(99) < 80) nid = known_id();
         else nid = ID_W'($urandom);
         issue(CMD_NEIGHBOR, ID_W'($urandom), nid);
         // repeated neighbor now and then
         if ($urandom_range(99) < 5) issue(CMD_NEIGHBOR, ID_W'($urandom), nid);
         sent += 1;
      end
      vid = ($urandom_range(99) < 15) ? known_id() : ID_W'($urandom);
      issue(CMD_PLACE, vid, ID_W'($urandom));
      sent += 1;
   endtask

   initial begin
      int unsigned sent;
      logic [ALPHA_W-1:0] alphas [6];
      logic [ALPHA_W-1:0] cands [6];
      no_gaps = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: seed all partitions at reset settings, edges of the id fields
      issue(CMD_NEIGHBOR, 16'hFFFF, 16'h0000);   // unassigned neighbor
      issue(CMD_PLACE, 16'h0000, 16'hFFFF);
      issue(CMD_PLACE, 16'hFFFF, 16'h0000);
      issue(CMD_NEIGHBOR, 16'h0000, 16'h0000);   // seed ignores neighbor counts
      for (int i = 2; i < NUM_PARTITIONS; i++) issue(CMD_PLACE, ID_W'(i), 16'h0);
      // scored placements, repeated neighbor, repeated placement
      issue(CMD_NEIGHBOR, 16'h1234, 16'hFFFF);
      issue(CMD_NEIGHBOR, 16'h1234, 16'hFFFF);
      issue(CMD_NEIGHBOR, 16'h1234, 16'h0003);
      issue(CMD_PLACE, 16'h0100, 16'h0);
      issue(CMD_NEIGHBOR, 16'h0, 16'h0100);
      issue(CMD_PLACE, 16'h0000, 16'h0);
      drain();
      // candidate count of zero, alpha zero
      set_reg(REG_CAND, '0);
      set_reg(REG_ALPHA, '0);
      issue(CMD_NEIGHBOR, 16'h0, 16'h0005);
      issue(CMD_PLACE, 16'h0200, 16'h0);
      drain();
      // candidate count above the partition count, alpha at max
      set_reg(REG_CAND, 24'd15);
      set_reg(REG_ALPHA, 24'hFFFFFF);
      issue(CMD_NEIGHBOR, 16'h0, 16'h0006);
      issue(CMD_PLACE, 16'h0300, 16'h0);
      issue(CMD_PLACE, 16'hFFFF, 16'h0);
      drain();

      // random phases, each with its own register settings
      alphas = '{24'd32768, 24'd0, 24'hFFFFFF, 24'd4000, 24'd300000, 24'd65536};
      cands  = '{24'd4, 24'd1, 24'd8, 24'd15, 24'd0, 24'd2};
      for (int ph = 0; ph < 6; ph++) begin
         set_reg(REG_ALPHA, (ph == 5) ? ALPHA_W'($urandom) : alphas[ph]);
         set_reg(REG_CAND, (ph == 5) ? ALPHA_W'($urandom_range(0, 15)) : cands[ph]);
         no_gaps = (ph == 3);   // one long stretch with back-to-back requests
         sent = 0;
         while (sent < 270) begin
            if ($urandom_range(99) < 10) begin
               // noise: lone neighbor or bare place request
               issue($urandom_range(1) ? CMD_PLACE : CMD_NEIGHBOR,
                     ID_W'($urandom), ID_W'($urandom));
               sent += 1;
            end else begin
               vertex_burst(sent);
            end
         end
         drain();
      end

      if (fail_count == 0 && pending == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // overall watchdog, allows for the owner clear after reset and slow scoring
   initial begin
      #60_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
rtl/core/sgpa_pkg.sv
rtl/core/sgpa_ram.sv
rtl/core/sgpa_isqrt.sv
rtl/core/streaming_graph_partition_assign_unit.sv
rtl/core/sgpa_checker.sv
tb/sv/sgpa_checker.sv
tb/sv/tb_streaming_graph_partition_assign_unit.sv
